FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the oscillator bank RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/dco_pkg.sv
// ----------------------------------------------------------------------------
// Oscillator bank package
// Shared widths, codes, note increment table builder and reciprocal table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dco_pkg;

    localparam int DEF_MAX_VOICES   = 8;
    localparam int DEF_FADE_SAMPLES = 1024;
    localparam int DEF_SAMPLE_RATE  = 48000;

    localparam int FUNC_W      = 2;
    localparam int NOTE_W      = 7;
    localparam int SAMPLE_W    = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int PHASE_W     = 32;
    localparam int GAIN_W      = 9;
    localparam int SUM_W       = 18;
    localparam int VOICE_IDX_W = 4;
    localparam int VOICE_CNT_W = 5;

    localparam logic [5:0]     DETUNE_MAX = 6'd50;
    localparam logic [8:0]     GAIN_FULL  = 9'd256;
    localparam logic [11:0]    PPM_STEP   = 12'd38;
    localparam int             SAMPLE_MAX = 2047;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_COMMIT = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE   = 3'd0,
        CFG_DETUNE = 3'd1,
        CFG_CUTOFF = 3'd2,
        CFG_WIDTH  = 3'd3,
        CFG_ENABLE = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic                   valid;
        logic                   bank;
        logic [VOICE_IDX_W-1:0] vidx;
        logic [VOICE_CNT_W-1:0] cnt;
        logic [GAIN_W-1:0]      gain;
    } voice_issue_t;

    typedef struct packed {
        logic       wave_sel;
        logic [5:0] detune;
        logic [7:0] width;
    } voice_cfg_t;

    typedef logic [PHASE_W-1:0] note_rom_t [128];

    // 2^(r/12) scaled by 10^16
    localparam logic [63:0] SEMITONE_RATIO [12] = '{
        64'd10000000000000000, 64'd10594630943592953, 64'd11224620483093730,
        64'd11892071150027211, 64'd12599210498948732, 64'd13348398541700344,
        64'd14142135623730950, 64'd14983070768766815, 64'd15874010519681995,
        64'd16817928305074291, 64'd17817974362806786, 64'd18877486253633870
    };

    // Rounded phase increment per MIDI note, built by long division at elaboration
    function automatic note_rom_t build_note_rom(input longint unsigned sample_rate);
        note_rom_t   rom;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] q;
        int          r;
        int          s;
        den = 64'(sample_rate) * 64'd152587890625;
        r = 3;
        s = 10;
        for (int n = 0; n < 128; n++) begin
            num = 64'd440 * SEMITONE_RATIO[r];
            rem = '0;
            q   = '0;
            for (int i = 63; i >= 0; i--) begin
                rem = {rem[62:0], num[i]};
                q   = {q[62:0], 1'b0};
                if (rem >= den) begin
                    rem  = rem - den;
                    q[0] = 1'b1;
                end
            end
            for (int j = 0; j < s; j++) begin
                rem = {rem[62:0], 1'b0};
                q   = {q[62:0], 1'b0};
                if (rem >= den) begin
                    rem  = rem - den;
                    q[0] = 1'b1;
                end
            end
            if ({rem[62:0], 1'b0} >= den) q = q + 64'd1;
            rom[n] = q[31:0];
            r = r + 1;
            if (r == 12) begin
                r = 0;
                s = s + 1;
            end
        end
        return rom;
    endfunction

    // ceil(2^16 / d); exact floor division for numerators up to 750
    function automatic logic [16:0] recip_q16(input logic [3:0] d);
        logic [16:0] v;
        case (d)
            4'd1:    v = 17'd65536;
            4'd2:    v = 17'd32768;
            4'd3:    v = 17'd21846;
            4'd4:    v = 17'd16384;
            4'd5:    v = 17'd13108;
            4'd6:    v = 17'd10923;
            4'd7:    v = 17'd9363;
            4'd8:    v = 17'd8192;
            4'd9:    v = 17'd7282;
            4'd10:   v = 17'd6554;
            4'd11:   v = 17'd5958;
            4'd12:   v = 17'd5462;
            4'd13:   v = 17'd5042;
            4'd14:   v = 17'd4682;
            4'd15:   v = 17'd4370;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/dco_channels.sv
// ----------------------------------------------------------------------------
// Oscillator bank channels
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dco_in_if;
    logic                          valid;
    logic                          ready;
    logic [dco_pkg::FUNC_W-1:0]    func;
    logic [dco_pkg::NOTE_W-1:0]    note;
    modport source (output valid, output func, output note, input ready);
    modport sink   (input valid, input func, input note, output ready);
endinterface

interface dco_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dco_pkg::SAMPLE_W-1:0]  left_sample;
    logic signed [dco_pkg::SAMPLE_W-1:0]  right_sample;
    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface dco_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dco_pkg::CFG_IDX_W-1:0]     index;
    logic [dco_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/dco_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dco_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/dco_voice_pipe.sv
// ----------------------------------------------------------------------------
// Voice pipeline
// Per-voice read-modify-write: increment lookup, detune, phase write-back,
// waveform, panning, crossfade weighting and accumulation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dco_voice_pipe #(
    parameter int MAX_VOICES  = dco_pkg::DEF_MAX_VOICES,
    parameter int SAMPLE_RATE = dco_pkg::DEF_SAMPLE_RATE,
    parameter int VW          = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1,
    parameter int RW          = dco_pkg::NOTE_W + dco_pkg::PHASE_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dco_pkg::voice_issue_t               issue,
    input  dco_pkg::voice_cfg_t                 vcfg,
    input  logic                                clear,
    input  logic [RW-1:0]                       rdata,
    output logic                                wr_en,
    output logic [VW:0]                         wr_addr,
    output logic [RW-1:0]                       wr_data,
    output logic                                busy,
    output logic signed [dco_pkg::SUM_W-1:0]    sum_l,
    output logic signed [dco_pkg::SUM_W-1:0]    sum_r
);

    localparam dco_pkg::note_rom_t NOTE_ROM = dco_pkg::build_note_rom(SAMPLE_RATE);
    localparam int PW = dco_pkg::PHASE_W;
    localparam int GW = dco_pkg::GAIN_W;
    localparam int IW = dco_pkg::VOICE_IDX_W;
    localparam int CNW = dco_pkg::VOICE_CNT_W;

    logic [7:0] vld_reg;

    // stage 0: issue registers, RAM data arrives
    logic           s0_bank_reg;
    logic [IW-1:0]  s0_v_reg;
    logic [CNW-1:0] s0_cnt_reg;
    logic [GW-1:0]  s0_gain_reg;
    // stage 1
    logic [PW-1:0]  s1_base_reg, s1_phase_reg;
    logic [dco_pkg::NOTE_W-1:0] s1_note_reg;
    logic           s1_bank_reg;
    logic [IW-1:0]  s1_v_reg;
    logic [GW-1:0]  s1_gain_reg;
    logic [9:0]     s1_mag_reg;
    logic           s1_neg_reg, s1_on_reg;
    logic [3:0]     s1_d_reg;
    // stage 2
    logic [PW-1:0]  s2_base_reg, s2_phase_reg;
    logic [dco_pkg::NOTE_W-1:0] s2_note_reg;
    logic           s2_bank_reg;
    logic [IW-1:0]  s2_v_reg;
    logic [GW-1:0]  s2_gain_reg;
    logic signed [6:0] s2_spread_reg;
    // stage 3
    logic [PW-1:0]  s3_base_reg, s3_phase_reg;
    logic [dco_pkg::NOTE_W-1:0] s3_note_reg;
    logic           s3_bank_reg;
    logic [IW-1:0]  s3_v_reg;
    logic [GW-1:0]  s3_gain_reg;
    logic signed [11:0] s3_ppm_reg;
    // stage 4
    logic [PW-1:0]  s4_base_reg, s4_phase_reg;
    logic [dco_pkg::NOTE_W-1:0] s4_note_reg;
    logic           s4_bank_reg;
    logic [IW-1:0]  s4_v_reg;
    logic [GW-1:0]  s4_gain_reg;
    logic signed [44:0] s4_prod_reg;
    // stage 5
    logic [PW-1:0]  s5_phase_reg;
    logic           s5_odd_reg;
    logic [GW-1:0]  s5_gain_reg;
    // stage 6
    logic signed [20:0] s6_pl_reg, s6_pr_reg;
    logic [GW-1:0]  s6_gain_reg;
    // stage 7
    logic signed [22:0] s7_tl_reg, s7_tr_reg;

    logic signed [dco_pkg::SUM_W-1:0] sum_l_reg, sum_r_reg;

    // stage 0 logic
    logic signed [6:0] diff;
    logic [5:0]        dmag;
    logic [PW-1:0]     base;
    // stage 1 logic
    logic [26:0]       qfull;
    logic [5:0]        q;
    logic signed [6:0] spread;
    // stage 2..4
    logic signed [11:0] ppm;
    logic signed [44:0] prod;
    logic [PW-1:0]      inc;
    logic [PW-1:0]      new_phase;
    // stage 5
    logic signed [15:0] saw;
    logic signed [16:0] saw17;
    logic signed [16:0] amag;
    logic signed [17:0] tri_w;
    logic signed [17:0] w;
    logic signed [10:0] smp;
    logic [6:0]         half;
    logic [8:0]         g_near, g_far, gl, gr;
    // stage 6
    logic signed [12:0] pl_s, pr_s;
    // stage 7
    logic signed [14:0] tl_s, tr_s;

    always_comb
    begin
        diff = $signed({2'b00, s0_v_reg, 1'b0}) - $signed({2'b00, s0_cnt_reg}) + 7'sd1;
        dmag = diff[6] ? 6'(-diff) : 6'(diff);
        base = NOTE_ROM[rdata[RW-1:PW]];

        qfull  = 27'(s1_mag_reg) * 27'(dco_pkg::recip_q16(s1_d_reg));
        q      = qfull[21:16];
        spread = !s1_on_reg ? 7'sd0 : (s1_neg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q}));

        ppm  = s2_spread_reg * $signed(dco_pkg::PPM_STEP);
        prod = $signed({1'b0, s3_base_reg}) * s3_ppm_reg;

        inc       = s4_base_reg + PW'(s4_prod_reg >>> 16);
        new_phase = s4_phase_reg + inc;

        saw   = $signed({~s5_phase_reg[PW-1], s5_phase_reg[PW-2:PW-16]});
        saw17 = 17'(saw);
        amag  = saw17[16] ? -saw17 : saw17;
        tri_w = (18'(amag) - 18'sd16384) * 18'sd2;
        w     = vcfg.wave_sel ? tri_w : 18'(saw);
        smp   = 11'(w >>> 7);
        half  = vcfg.width[7:1];
        g_near = 9'd128 + 9'(half);
        g_far  = 9'd128 - 9'(half);
        gl = s5_odd_reg ? g_far : g_near;
        gr = s5_odd_reg ? g_near : g_far;

        pl_s = 13'(s6_pl_reg >>> 8);
        pr_s = 13'(s6_pr_reg >>> 8);
        tl_s = 15'(s7_tl_reg >>> 8);
        tr_s = 15'(s7_tr_reg >>> 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[6:0], issue.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        s0_bank_reg <= issue.bank;
        s0_v_reg    <= issue.vidx;
        s0_cnt_reg  <= issue.cnt;
        s0_gain_reg <= issue.gain;

        s1_base_reg  <= base;
        s1_phase_reg <= rdata[PW-1:0];
        s1_note_reg  <= rdata[RW-1:PW];
        s1_bank_reg  <= s0_bank_reg;
        s1_v_reg     <= s0_v_reg;
        s1_gain_reg  <= s0_gain_reg;
        s1_mag_reg   <= 10'(vcfg.detune) * 10'(dmag);
        s1_neg_reg   <= diff[6];
        s1_on_reg    <= (s0_cnt_reg > CNW'(1));
        s1_d_reg     <= 4'(s0_cnt_reg - CNW'(1));

        s2_base_reg   <= s1_base_reg;
        s2_phase_reg  <= s1_phase_reg;
        s2_note_reg   <= s1_note_reg;
        s2_bank_reg   <= s1_bank_reg;
        s2_v_reg      <= s1_v_reg;
        s2_gain_reg   <= s1_gain_reg;
        s2_spread_reg <= spread;

        s3_base_reg  <= s2_base_reg;
        s3_phase_reg <= s2_phase_reg;
        s3_note_reg  <= s2_note_reg;
        s3_bank_reg  <= s2_bank_reg;
        s3_v_reg     <= s2_v_reg;
        s3_gain_reg  <= s2_gain_reg;
        s3_ppm_reg   <= ppm;

        s4_base_reg  <= s3_base_reg;
        s4_phase_reg <= s3_phase_reg;
        s4_note_reg  <= s3_note_reg;
        s4_bank_reg  <= s3_bank_reg;
        s4_v_reg     <= s3_v_reg;
        s4_gain_reg  <= s3_gain_reg;
        s4_prod_reg  <= prod;

        s5_phase_reg <= new_phase;
        s5_odd_reg   <= s4_v_reg[0];
        s5_gain_reg  <= s4_gain_reg;

        s6_pl_reg   <= smp * $signed({1'b0, gl});
        s6_pr_reg   <= smp * $signed({1'b0, gr});
        s6_gain_reg <= s5_gain_reg;

        s7_tl_reg <= pl_s * $signed({1'b0, s6_gain_reg});
        s7_tr_reg <= pr_s * $signed({1'b0, s6_gain_reg});

        if (clear)
        begin
            sum_l_reg <= '0;
            sum_r_reg <= '0;
        end
        else if (vld_reg[7])
        begin
            sum_l_reg <= sum_l_reg + dco_pkg::SUM_W'(tl_s);
            sum_r_reg <= sum_r_reg + dco_pkg::SUM_W'(tr_s);
        end
    end

    // phase write-back keeps the note alongside
    assign wr_en   = vld_reg[4];
    assign wr_addr = {s4_bank_reg, s4_v_reg[VW-1:0]};
    assign wr_data = {s4_note_reg, new_phase};
    assign busy    = |vld_reg;
    assign sum_l   = sum_l_reg;
    assign sum_r   = sum_r_reg;

endmodule

FILE: hdl/dco_lowpass.sv
// ----------------------------------------------------------------------------
// Stereo lowpass
// One-pole lowpass per channel with output clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dco_lowpass (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [dco_pkg::SUM_W-1:0]       sum_l,
    input  logic signed [dco_pkg::SUM_W-1:0]       sum_r,
    input  logic [7:0]                             cutoff,
    output logic                                   done,
    output logic signed [dco_pkg::SAMPLE_W-1:0]    left,
    output logic signed [dco_pkg::SAMPLE_W-1:0]    right
);

    localparam int SW = dco_pkg::SAMPLE_W;

    logic               mul_vld_reg, upd_vld_reg;
    logic signed [15:0] lvl_reg  [2];
    logic signed [28:0] prod_reg [2];
    logic signed [18:0] diff     [2];
    logic signed [28:0] prod     [2];
    logic signed [SW-1:0] clamp  [2];
    logic signed [9:0]  k;

    always_comb
    begin
        k = $signed({2'b00, cutoff}) + 10'sd1;
        diff[0] = 19'(sum_l) - 19'(lvl_reg[0]);
        diff[1] = 19'(sum_r) - 19'(lvl_reg[1]);
        for (int c = 0; c < 2; c++)
        begin
            prod[c] = diff[c] * k;
            if (lvl_reg[c] > 16'(dco_pkg::SAMPLE_MAX))
                clamp[c] = SW'(dco_pkg::SAMPLE_MAX);
            else if (lvl_reg[c] < -16'(dco_pkg::SAMPLE_MAX))
                clamp[c] = -SW'(dco_pkg::SAMPLE_MAX);
            else
                clamp[c] = SW'(lvl_reg[c]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            upd_vld_reg <= 1'b0;
            lvl_reg[0]  <= '0;
            lvl_reg[1]  <= '0;
        end
        else
        begin
            mul_vld_reg <= start;
            upd_vld_reg <= mul_vld_reg;
            if (mul_vld_reg)
            begin
                lvl_reg[0] <= lvl_reg[0] + 16'(prod_reg[0] >>> 8);
                lvl_reg[1] <= lvl_reg[1] + 16'(prod_reg[1] >>> 8);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg[0] <= prod[0];
        prod_reg[1] <= prod[1];
    end

    assign done  = upd_vld_reg;
    assign left  = clamp[0];
    assign right = clamp[1];

endmodule

FILE: hdl/detuned_chord_oscillator_bank_unit.sv
// ----------------------------------------------------------------------------
// Detuned chord oscillator bank
// Tick: walks the voices of the banks with nonzero crossfade gain (up to
// 2 x MAX_VOICES in all), one voice RAM read per cycle.
// Append: stores a pending note. Commit: copy loop. Disabled tick: zero samples.
// One request in flight; the result register frees it.
// Reset: control, counts, crossfade and filter levels clear; no RAM clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module detuned_chord_oscillator_bank_unit #(
    parameter int MAX_VOICES   = dco_pkg::DEF_MAX_VOICES,
    parameter int FADE_SAMPLES = dco_pkg::DEF_FADE_SAMPLES,
    parameter int SAMPLE_RATE  = dco_pkg::DEF_SAMPLE_RATE
) (
    input  logic              clk,
    input  logic              rst_n,
    dco_in_if.sink            item,
    dco_out_if.source         result,
    dco_cfg_if.sink           cfg
);

    localparam int VW     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CW     = $clog2(MAX_VOICES + 1);
    localparam int FW     = $clog2(FADE_SAMPLES + 1);
    localparam int RW     = dco_pkg::NOTE_W + dco_pkg::PHASE_W;
    localparam int GW     = dco_pkg::GAIN_W;
    localparam int SW     = dco_pkg::SAMPLE_W;
    localparam int STEP_Q = 256 / FADE_SAMPLES;
    localparam int STEP_R = 256 % FADE_SAMPLES;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_COPY  = 6'b000010,
        ST_ISSUE = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_FILT  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic          wave_reg, en_reg;
    logic [5:0]    det_reg;
    logic [7:0]    cut_reg, width_reg;
    logic          active_reg, active_next;
    logic [FW-1:0] fade_reg, fade_next;
    logic [GW-1:0] gnew_reg, gnew_next;
    logic [FW-1:0] grem_reg, grem_next;
    logic [GW-1:0] gain_reg [2];
    logic [GW-1:0] gain_next [2];
    logic [CW-1:0] pcount_reg, pcount_next;
    logic [CW-1:0] bcount_reg [2];
    logic [CW-1:0] bcount_next [2];
    logic          bank_sel_reg, bank_sel_next;
    logic [CW-1:0] vidx_reg, vidx_next;
    logic [CW-1:0] copy_n_reg, copy_n_next;
    logic          copy_wr_reg;
    logic [VW-1:0] copy_widx_reg;
    logic          copy_wbank_reg;
    logic signed [SW-1:0] res_l_reg, res_l_next, res_r_reg, res_r_next;
    logic          out_valid_reg, out_valid_next;
    logic signed [SW-1:0] out_l_reg, out_l_next, out_r_reg, out_r_next;

    logic          item_acc, commit_acc;
    logic          pend_we, copy_re, do_issue, lp_start, pipe_clear;
    logic [CW-1:0] cur_cnt;
    logic [GW-1:0] cur_gain, g_act, g_old;
    logic [FW:0]   rem_sum;
    logic [dco_pkg::NOTE_W-1:0] pend_rdata;
    logic [RW-1:0] vram_rdata, vram_wdata, pipe_wdata;
    logic [VW:0]   vram_waddr, pipe_waddr;
    logic          vram_we, pipe_we, pipe_busy, lp_done;
    logic signed [dco_pkg::SUM_W-1:0] sum_l, sum_r;
    logic signed [SW-1:0] lp_l, lp_r;
    logic [5:0]    det_sat;
    dco_pkg::voice_issue_t issue;
    dco_pkg::voice_cfg_t   vcfg;

    assign item_acc   = item.valid & item.ready;
    assign commit_acc = item_acc && (item.func == dco_pkg::FUNC_COMMIT);
    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign cur_cnt  = bcount_reg[bank_sel_reg];
    assign cur_gain = gain_reg[bank_sel_reg];
    assign g_act    = (fade_reg != '0) ? gnew_reg : dco_pkg::GAIN_FULL;
    assign g_old    = (fade_reg != '0) ? (dco_pkg::GAIN_FULL - gnew_reg) : '0;
    assign rem_sum  = {1'b0, grem_reg} + (FW + 1)'(STEP_R);
    assign det_sat  = (det_reg > dco_pkg::DETUNE_MAX) ? dco_pkg::DETUNE_MAX : det_reg;

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        fade_next      = fade_reg;
        gnew_next      = gnew_reg;
        grem_next      = grem_reg;
        gain_next      = gain_reg;
        pcount_next    = pcount_reg;
        bcount_next    = bcount_reg;
        bank_sel_next  = bank_sel_reg;
        vidx_next      = vidx_reg;
        copy_n_next    = copy_n_reg;
        res_l_next     = res_l_reg;
        res_r_next     = res_r_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        out_valid_next = out_valid_reg & ~result.ready;
        pend_we        = 1'b0;
        copy_re        = 1'b0;
        do_issue       = 1'b0;
        lp_start       = 1'b0;
        pipe_clear     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    case (dco_pkg::func_t'(item.func))
                        dco_pkg::FUNC_TICK:
                        begin
                            if (en_reg)
                            begin
                                gain_next[active_reg]  = g_act;
                                gain_next[~active_reg] = g_old;
                                pipe_clear    = 1'b1;
                                bank_sel_next = 1'b0;
                                vidx_next     = '0;
                                state_next    = ST_ISSUE;
                            end
                            else
                            begin
                                res_l_next = '0;
                                res_r_next = '0;
                                state_next = ST_OUT;
                            end
                        end
                        dco_pkg::FUNC_APPEND:
                        begin
                            if (pcount_reg < CW'(MAX_VOICES))
                            begin
                                pend_we     = 1'b1;
                                pcount_next = pcount_reg + CW'(1);
                            end
                        end
                        dco_pkg::FUNC_COMMIT:
                        begin
                            bcount_next[~active_reg] = pcount_reg;
                            active_next = ~active_reg;
                            fade_next   = FW'(FADE_SAMPLES);
                            gnew_next   = '0;
                            grem_next   = '0;
                            pcount_next = '0;
                            if (pcount_reg != '0)
                            begin
                                bank_sel_next = ~active_reg;
                                vidx_next     = '0;
                                copy_n_next   = pcount_reg;
                                state_next    = ST_COPY;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                copy_re   = 1'b1;
                vidx_next = vidx_reg + CW'(1);
                if (vidx_reg == copy_n_reg - CW'(1))
                    state_next = ST_IDLE;
            end
            ST_ISSUE:
            begin
                if (cur_gain != '0 && vidx_reg < cur_cnt)
                begin
                    do_issue  = 1'b1;
                    vidx_next = vidx_reg + CW'(1);
                end
                else if (!bank_sel_reg)
                begin
                    bank_sel_next = 1'b1;
                    vidx_next     = '0;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    lp_start   = 1'b1;
                    state_next = ST_FILT;
                end
            end
            ST_FILT:
            begin
                if (lp_done)
                begin
                    res_l_next = lp_l;
                    res_r_next = lp_r;
                    if (fade_reg != '0)
                    begin
                        fade_next = fade_reg - FW'(1);
                        // running floor(256 * elapsed / FADE_SAMPLES)
                        if (rem_sum >= (FW + 1)'(FADE_SAMPLES))
                        begin
                            grem_next = FW'(rem_sum - (FW + 1)'(FADE_SAMPLES));
                            gnew_next = gnew_reg + GW'(STEP_Q + 1);
                        end
                        else
                        begin
                            grem_next = FW'(rem_sum);
                            gnew_next = gnew_reg + GW'(STEP_Q);
                        end
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_l_next     = res_l_reg;
                    out_r_next     = res_r_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wave_reg      <= 1'b0;
            det_reg       <= '0;
            cut_reg       <= '0;
            width_reg     <= '0;
            en_reg        <= 1'b0;
            active_reg    <= 1'b0;
            fade_reg      <= '0;
            gnew_reg      <= '0;
            grem_reg      <= '0;
            gain_reg[0]   <= '0;
            gain_reg[1]   <= '0;
            pcount_reg    <= '0;
            bcount_reg[0] <= '0;
            bcount_reg[1] <= '0;
            bank_sel_reg  <= 1'b0;
            vidx_reg      <= '0;
            copy_n_reg    <= '0;
            copy_wr_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            fade_reg      <= fade_next;
            gnew_reg      <= gnew_next;
            grem_reg      <= grem_next;
            gain_reg      <= gain_next;
            pcount_reg    <= pcount_next;
            bcount_reg    <= bcount_next;
            bank_sel_reg  <= bank_sel_next;
            vidx_reg      <= vidx_next;
            copy_n_reg    <= copy_n_next;
            copy_wr_reg   <= copy_re;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (dco_pkg::cfg_idx_t'(cfg.index))
                    dco_pkg::CFG_WAVE:   wave_reg  <= cfg.data[0];
                    dco_pkg::CFG_DETUNE: det_reg   <= cfg.data[5:0];
                    dco_pkg::CFG_CUTOFF: cut_reg   <= cfg.data;
                    dco_pkg::CFG_WIDTH:  width_reg <= cfg.data;
                    dco_pkg::CFG_ENABLE: en_reg    <= cfg.data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_l_reg      <= res_l_next;
        res_r_reg      <= res_r_next;
        out_l_reg      <= out_l_next;
        out_r_reg      <= out_r_next;
        copy_widx_reg  <= vidx_reg[VW-1:0];
        copy_wbank_reg <= bank_sel_reg;
    end

    assign result.valid        = out_valid_reg;
    assign result.left_sample  = out_l_reg;
    assign result.right_sample = out_r_reg;

    // copy writes and phase write-backs never share a cycle
    assign vram_we    = copy_wr_reg | pipe_we;
    assign vram_waddr = copy_wr_reg ? {copy_wbank_reg, copy_widx_reg} : pipe_waddr;
    assign vram_wdata = copy_wr_reg ? {pend_rdata, dco_pkg::PHASE_W'(0)} : pipe_wdata;

    assign issue.valid = do_issue;
    assign issue.bank  = bank_sel_reg;
    assign issue.vidx  = dco_pkg::VOICE_IDX_W'(vidx_reg);
    assign issue.cnt   = dco_pkg::VOICE_CNT_W'(cur_cnt);
    assign issue.gain  = cur_gain;

    assign vcfg.wave_sel = wave_reg;
    assign vcfg.detune   = det_sat;
    assign vcfg.width    = width_reg;

    dco_ram #(
        .WIDTH (dco_pkg::NOTE_W),
        .DEPTH (MAX_VOICES)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pcount_reg[VW-1:0]),
        .wdata (item.note),
        .re    (copy_re),
        .raddr (vidx_reg[VW-1:0]),
        .rdata (pend_rdata)
    );

    dco_ram #(
        .WIDTH (RW),
        .DEPTH (2 << VW)
    ) u_voice_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .re    (do_issue),
        .raddr ({bank_sel_reg, vidx_reg[VW-1:0]}),
        .rdata (vram_rdata)
    );

    dco_voice_pipe #(
        .MAX_VOICES  (MAX_VOICES),
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_voice_pipe (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .vcfg    (vcfg),
        .clear   (pipe_clear),
        .rdata   (vram_rdata),
        .wr_en   (pipe_we),
        .wr_addr (pipe_waddr),
        .wr_data (pipe_wdata),
        .busy    (pipe_busy),
        .sum_l   (sum_l),
        .sum_r   (sum_r)
    );

    dco_lowpass u_lowpass (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lp_start),
        .sum_l  (sum_l),
        .sum_r  (sum_r),
        .cutoff (cut_reg),
        .done   (lp_done),
        .left   (lp_l),
        .right  (lp_r)
    );

    `ASSERT_ALWAYS(a_pend_bound, clk, rst_n, pcount_reg <= CW'(MAX_VOICES), "pending count overrun")
    `ASSERT_ALWAYS(a_rem_bound, clk, rst_n, grem_reg < FW'(FADE_SAMPLES), "fade remainder overrun")
    `ASSERT_ALWAYS(a_wr_excl, clk, rst_n, !(copy_wr_reg && pipe_we), "voice RAM write clash")
    `ASSERT_NEXT(a_commit_fade, clk, rst_n, commit_acc, fade_reg == FW'(FADE_SAMPLES), "no fade")

endmodule
